// ===== rtl/core/rmpi_pkg.sv =====
package rmpi_pkg;

    // Sizing of the lock unit
    localparam int MAX_TASKS = 16;
    localparam int NEST_BITS = 16;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int TASK_W   = 4;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 3;

    // Waiter list addressing: slot index and fill count
    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [NEST_BITS-1:0] DEPTH_MAX = {NEST_BITS{1'b1}};

    // Request kinds
    localparam logic [FUNC_W-1:0] FUNC_PEND    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_STARTED = 3'd1,
        ST_BAD         = 3'd2,
        ST_TIMEOUT     = 3'd3,
        ST_QUEUED      = 3'd4,
        ST_FULL        = 3'd5,
        ST_NEST        = 3'd6
    } status_t;

    // One waiter list entry as stored in the list memory
    typedef struct packed {
        logic [TASK_W-1:0] id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/rmpi_ifs.sv =====
interface rmpi_req_if import rmpi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] task_prio;
    logic              no_wait;

    modport source (output valid, func, task_id, task_prio, no_wait, input ready);
    modport sink   (input valid, func, task_id, task_prio, no_wait, output ready);
endinterface

interface rmpi_rsp_if import rmpi_pkg::*; ();
    logic              valid;
    logic              ready;
    status_t           status;
    logic              prio_valid;
    logic [TASK_W-1:0] prio_task;
    logic [PRIO_W-1:0] prio_value;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
    logic              last;

    modport source (output valid, status, prio_valid, prio_task, prio_value,
                    wake_valid, wake_task, last, input ready);
    modport sink   (input valid, status, prio_valid, prio_task, prio_value,
                    wake_valid, wake_task, last, output ready);
endinterface

interface rmpi_cfg_if ();
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/rmpi_ram.sv =====
module rmpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/recursive_mutex_prio_inherit.sv =====
// Lock unit for one recursive mutex with priority inheritance.
// Channels: req carries pend, release and delete requests (task id, priority,
// no-wait flag); rsp returns results, each with a status, an optional
// priority change for the scheduler, an optional woken task and a last flag;
// cfg writes the scheduler-running bit, one write per cycle, always ready.
// One request is handled at a time; req is ready only while the sequencer
// is idle. The result of a request that needs no list access is loaded into
// the output register from S_RESP after S_DECIDE, and no new request is
// taken until the sequencer is back in idle. A queued pend walks the
// waiter list from its tail, one entry per cycle through the single list
// memory port pair. A release that hands the lock over adds a head read in
// S_REL_HEAD. Delete returns one result per waiter, one per cycle while rsp
// is not stalled.
// The list is a circular buffer in memory, so handing over the lock only
// advances the head pointer. Reset empties the list, frees the mutex and
// clears the running bit; no clearing pass is needed. When rsp stalls, the
// result is held in the output register and the sequencer waits for it.
module recursive_mutex_prio_inherit import rmpi_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    rmpi_cfg_if.sink    cfg,
    rmpi_req_if.sink    req,
    rmpi_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_CMP,
        S_INS_HEAD,
        S_REL_HEAD,
        S_DEL_NEXT,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic                 os_running_reg, os_running_next;
    logic [TASK_W-1:0]    owner_reg, owner_next;
    logic [NEST_BITS-1:0] depth_reg, depth_next;
    logic [PRIO_W-1:0]    saved_reg, saved_next;
    logic [PRIO_W-1:0]    live_reg, live_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        lidx_reg, lidx_next;
    logic [CW-1:0]        remain_reg, remain_next;

    // Latched request
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [TASK_W-1:0]    id_reg, id_next;
    logic [PRIO_W-1:0]    prio_reg, prio_next;
    logic                 nw_reg, nw_next;

    // Pending result fields
    status_t              st_reg, st_next;
    logic                 pv_reg, pv_next;
    logic [TASK_W-1:0]    pt_reg, pt_next;
    logic [PRIO_W-1:0]    pval_reg, pval_next;
    logic                 wv_reg, wv_next;
    logic [TASK_W-1:0]    wt_reg, wt_next;

    // Output register
    logic                 ov_reg, ov_next;
    status_t              ost_reg, ost_next;
    logic                 opv_reg, opv_next;
    logic [TASK_W-1:0]    opt_reg, opt_next;
    logic [PRIO_W-1:0]    opval_reg, opval_next;
    logic                 owv_reg, owv_next;
    logic [TASK_W-1:0]    owt_reg, owt_next;
    logic                 olast_reg, olast_next;

    // List memory port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    entry_t               rd_entry;
    entry_t               new_entry;
    logic                 out_free;
    logic [AW:0]          tail_sum;
    logic [AW-1:0]        tail_ptr;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(MAX_TASKS - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(MAX_TASKS - 1) : p - AW'(1);
    endfunction

    rmpi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign new_entry = '{id: id_reg, prio: prio_reg};
    assign out_free  = !ov_reg || rsp.ready;

    // Locate the physical slot of the last waiter
    assign tail_sum = (AW + 1)'({1'b0, head_reg}) + (AW + 1)'(count_reg) - (AW + 1)'(1);
    assign tail_ptr = (tail_sum >= (AW + 1)'(MAX_TASKS))
                    ? AW'(tail_sum - (AW + 1)'(MAX_TASKS)) : AW'(tail_sum);

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid      = ov_reg;
    assign rsp.status     = ost_reg;
    assign rsp.prio_valid = opv_reg;
    assign rsp.prio_task  = opt_reg;
    assign rsp.prio_value = opval_reg;
    assign rsp.wake_valid = owv_reg;
    assign rsp.wake_task  = owt_reg;
    assign rsp.last       = olast_reg;

    // Sequence one request
    always_comb
    begin
        state_next      = state_reg;
        os_running_next = os_running_reg;
        owner_next      = owner_reg;
        depth_next      = depth_reg;
        saved_next      = saved_reg;
        live_next       = live_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        ptr_next        = ptr_reg;
        lidx_next       = lidx_reg;
        remain_next     = remain_reg;
        func_next       = func_reg;
        id_next         = id_reg;
        prio_next       = prio_reg;
        nw_next         = nw_reg;
        st_next         = st_reg;
        pv_next         = pv_reg;
        pt_next         = pt_reg;
        pval_next       = pval_reg;
        wv_next         = wv_reg;
        wt_next         = wt_reg;
        ov_next         = ov_reg;
        ost_next        = ost_reg;
        opv_next        = opv_reg;
        opt_next        = opt_reg;
        opval_next      = opval_reg;
        owv_next        = owv_reg;
        owt_next        = owt_reg;
        olast_next      = olast_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg;

        // Take configuration writes at any time
        if (cfg.valid)
        begin
            os_running_next = cfg.data;
        end

        // Drop the result once taken
        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    id_next    = req.task_id;
                    prio_next  = req.task_prio;
                    nw_next    = req.no_wait;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                st_next    = ST_OK;
                pv_next    = 1'b0;
                pt_next    = '0;
                pval_next  = '0;
                wv_next    = 1'b0;
                wt_next    = '0;
                state_next = S_RESP;
                if (func_reg == FUNC_UNUSED)
                begin
                    state_next = S_IDLE;
                end
                else if (!os_running_reg)
                begin
                    st_next = ST_NOT_STARTED;
                end
                else
                begin
                    case (func_reg)
                        FUNC_PEND:
                        begin
                            if (depth_reg == '0)
                            begin
                                owner_next = id_reg;
                                saved_next = prio_reg;
                                live_next  = prio_reg;
                                depth_next = NEST_BITS'(1);
                            end
                            else if (owner_reg == id_reg)
                            begin
                                if (depth_reg == DEPTH_MAX)
                                begin
                                    st_next = ST_NEST;
                                end
                                else
                                begin
                                    depth_next = depth_reg + NEST_BITS'(1);
                                end
                            end
                            else if (nw_reg)
                            begin
                                st_next = ST_TIMEOUT;
                            end
                            else if (count_reg >= CW'(MAX_TASKS))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                st_next = ST_QUEUED;
                                // Boost the owner to the caller's priority
                                if (live_reg > prio_reg)
                                begin
                                    live_next = prio_reg;
                                    pv_next   = 1'b1;
                                    pt_next   = owner_reg;
                                    pval_next = prio_reg;
                                end
                                if (count_reg == '0)
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = head_reg;
                                    ram_wdata  = new_entry;
                                    count_next = count_reg + CW'(1);
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = tail_ptr;
                                    ptr_next   = tail_ptr;
                                    lidx_next  = AW'(count_reg - CW'(1));
                                    state_next = S_INS_CMP;
                                end
                            end
                        end

                        FUNC_RELEASE:
                        begin
                            if (depth_reg == '0 || owner_reg != id_reg)
                            begin
                                st_next = ST_BAD;
                            end
                            else if (depth_reg != NEST_BITS'(1))
                            begin
                                depth_next = depth_reg - NEST_BITS'(1);
                            end
                            else
                            begin
                                if (live_reg != saved_reg)
                                begin
                                    pv_next   = 1'b1;
                                    pt_next   = owner_reg;
                                    pval_next = saved_reg;
                                    live_next = saved_reg;
                                end
                                if (count_reg != '0)
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = head_reg;
                                    state_next = S_REL_HEAD;
                                end
                                else
                                begin
                                    owner_next = '0;
                                    depth_next = '0;
                                end
                            end
                        end

                        FUNC_DELETE:
                        begin
                            if (depth_reg != '0 && live_reg != saved_reg)
                            begin
                                pv_next   = 1'b1;
                                pt_next   = owner_reg;
                                pval_next = saved_reg;
                                live_next = saved_reg;
                            end
                            if (count_reg != '0)
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = head_reg;
                                ptr_next    = head_reg;
                                remain_next = count_reg;
                                state_next  = S_DEL_NEXT;
                            end
                        end

                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_CMP:
            begin
                // Shift a less urgent waiter up, or place the caller above it
                ram_we    = 1'b1;
                ram_waddr = ptr_inc(ptr_reg);
                if (prio_reg < rd_entry.prio)
                begin
                    ram_wdata = ram_rdata;
                    if (lidx_reg == '0)
                    begin
                        state_next = S_INS_HEAD;
                    end
                    else
                    begin
                        ptr_next  = ptr_dec(ptr_reg);
                        lidx_next = lidx_reg - AW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = ptr_dec(ptr_reg);
                    end
                end
                else
                begin
                    ram_wdata  = new_entry;
                    count_next = count_reg + CW'(1);
                    state_next = S_RESP;
                end
            end

            S_INS_HEAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = new_entry;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end

            S_REL_HEAD:
            begin
                // Hand the lock to the head waiter
                wv_next    = 1'b1;
                wt_next    = rd_entry.id;
                owner_next = rd_entry.id;
                saved_next = rd_entry.prio;
                live_next  = rd_entry.prio;
                depth_next = NEST_BITS'(1);
                head_next  = ptr_inc(head_reg);
                count_next = count_reg - CW'(1);
                state_next = S_RESP;
            end

            S_DEL_NEXT:
            begin
                // Wake one waiter per result
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_OK;
                    opv_next   = pv_reg;
                    opt_next   = pt_reg;
                    opval_next = pval_reg;
                    owv_next   = 1'b1;
                    owt_next   = rd_entry.id;
                    olast_next = (remain_reg == CW'(1));
                    pv_next    = 1'b0;
                    pt_next    = '0;
                    pval_next  = '0;
                    if (remain_reg == CW'(1))
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next    = ptr_inc(ptr_reg);
                        ram_re      = 1'b1;
                        ram_raddr   = ptr_inc(ptr_reg);
                        remain_next = remain_reg - CW'(1);
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    opv_next   = pv_reg;
                    opt_next   = pt_reg;
                    opval_next = pval_reg;
                    owv_next   = wv_reg;
                    owt_next   = wt_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            os_running_reg <= 1'b0;
            owner_reg      <= '0;
            depth_reg      <= '0;
            saved_reg      <= '0;
            live_reg       <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            ptr_reg        <= '0;
            lidx_reg       <= '0;
            remain_reg     <= '0;
            func_reg       <= '0;
            id_reg         <= '0;
            prio_reg       <= '0;
            nw_reg         <= 1'b0;
            st_reg         <= ST_OK;
            pv_reg         <= 1'b0;
            pt_reg         <= '0;
            pval_reg       <= '0;
            wv_reg         <= 1'b0;
            wt_reg         <= '0;
            ov_reg         <= 1'b0;
            ost_reg        <= ST_OK;
            opv_reg        <= 1'b0;
            opt_reg        <= '0;
            opval_reg      <= '0;
            owv_reg        <= 1'b0;
            owt_reg        <= '0;
            olast_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            os_running_reg <= os_running_next;
            owner_reg      <= owner_next;
            depth_reg      <= depth_next;
            saved_reg      <= saved_next;
            live_reg       <= live_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            ptr_reg        <= ptr_next;
            lidx_reg       <= lidx_next;
            remain_reg     <= remain_next;
            func_reg       <= func_next;
            id_reg         <= id_next;
            prio_reg       <= prio_next;
            nw_reg         <= nw_next;
            st_reg         <= st_next;
            pv_reg         <= pv_next;
            pt_reg         <= pt_next;
            pval_reg       <= pval_next;
            wv_reg         <= wv_next;
            wt_reg         <= wt_next;
            ov_reg         <= ov_next;
            ost_reg        <= ost_next;
            opv_reg        <= opv_next;
            opt_reg        <= opt_next;
            opval_reg      <= opval_next;
            owv_reg        <= owv_next;
            owt_reg        <= owt_next;
            olast_reg      <= olast_next;
        end
    end

    // The waiter list never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TASKS))
        else $error("waiter count above list size");

    // An accepted request is decided in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_DECIDE)
        else $error("accepted request not decided");

    // Placing the caller at the head grows the list by one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_HEAD |=> count_reg == $past(count_reg) + CW'(1))
        else $error("head insert did not grow the list");

    // The list memory is only written while a pend is being queued
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_DECIDE || state_reg == S_INS_CMP
                   || state_reg == S_INS_HEAD)
        else $error("list write outside a queued pend");

    // A handover always leaves the lock held once
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REL_HEAD |=> depth_reg == NEST_BITS'(1))
        else $error("handover left the lock free");

endmodule
